// ===== design/cci_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cci_pkg: shared types for the clamped complex integer ALU
// Operation codes, the controller-to-datapath command and datapath status structs.
// ----------------------------------------------------------------------------
package cci_pkg;

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	localparam int unsigned NUM_REGS = 4;
	localparam logic [1:0] REG_REAL_MIN = 2'd0;
	localparam logic [1:0] REG_REAL_MAX = 2'd1;
	localparam logic [1:0] REG_IMAG_MIN = 2'd2;
	localparam logic [1:0] REG_IMAG_MAX = 2'd3;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;   // latch the accepted item
		logic mul_a;     // form products ar*br, ai*bi, br*br
		logic mul_b;     // form products ar*bi, ai*br, bi*bi
		logic combine;   // form the exact new values (non-divide)
		logic div_start; // load divider
		logic div_step;  // one restoring step
		logic commit;    // clamp and write accumulator
	} cmd_t;

	typedef struct packed {
		logic div_last; // final divider step in progress
		logic is_div;   // captured op is divide with nonzero operand
		logic is_nop;   // captured op changes nothing
	} status_t;

endpackage
`default_nettype wire

// ===== design/cci_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cci_ctrl: sequencer of the complex ALU
// Walks each item through capture, the product states MUL_A and MUL_B, combine
// or divider load, divider steps for a divide, then commit and result transfer.
// ----------------------------------------------------------------------------
module cci_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  cci_pkg::status_t      sts,
	output cci_pkg::cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL_A, S_MUL_B, S_COMB, S_DIV, S_COMMIT, S_OUT
	} state_t;

	state_t state_q;

	// Accept a new item while idle or when the held result leaves this cycle
	assign in_ready  = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.capture   = in_valid && in_ready;
		cmd.mul_a     = (state_q == S_MUL_A);
		cmd.mul_b     = (state_q == S_MUL_B);
		cmd.combine   = (state_q == S_COMB) && !sts.is_div;
		cmd.div_start = (state_q == S_COMB) && sts.is_div;
		cmd.div_step  = (state_q == S_DIV);
		cmd.commit    = (state_q == S_COMMIT) && !sts.is_nop;
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_MUL_A;
				S_MUL_A:  state_q <= S_MUL_B;
				S_MUL_B:  state_q <= S_COMB;
				S_COMB:   state_q <= sts.is_div ? S_DIV : S_COMMIT;
				S_DIV:    if (sts.div_last) state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) state_q <= in_valid ? S_MUL_A : S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/cci_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cci_dp: datapath of the complex ALU
// Operand capture, product registers, a shared restoring divider that runs
// both quotients side by side, clamp logic and the accumulator.
// ----------------------------------------------------------------------------
module cci_dp #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  cci_pkg::cmd_t                     cmd,
	output cci_pkg::status_t                  sts,
	input  wire logic [2:0]                   mode,
	input  wire logic signed [DATA_WIDTH-1:0] operand_real,
	input  wire logic signed [DATA_WIDTH-1:0] operand_imag,
	input  wire logic signed [DATA_WIDTH-1:0] real_min,
	input  wire logic signed [DATA_WIDTH-1:0] real_max,
	input  wire logic signed [DATA_WIDTH-1:0] imag_min,
	input  wire logic signed [DATA_WIDTH-1:0] imag_max,
	output logic signed [DATA_WIDTH-1:0]      result_real,
	output logic signed [DATA_WIDTH-1:0]      result_imag,
	output logic                              real_clamped,
	output logic                              imag_clamped
);

	localparam int unsigned DW  = DATA_WIDTH;
	localparam int unsigned PW  = 2 * DW;      // product width
	localparam int unsigned SW  = 2 * DW + 1;  // sum of two products
	localparam int unsigned QW  = 2 * DW + 1;  // quotient magnitude bits
	localparam int unsigned CW  = $clog2(QW + 1);
	localparam logic [CW-1:0] LAST_STEP = CW'(QW - 1);

	logic [2:0]                 mode_q;
	logic signed [DW-1:0]       br_q, bi_q;
	logic signed [DW-1:0]       acc_re_q, acc_im_q;
	logic                       stk_re_q, stk_im_q;
	logic signed [PW-1:0]       p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_q, p_cc_q;
	logic signed [SW-1:0]       new_re_q, new_im_q;
	logic [SW-1:0]              den_q;
	logic [QW-1:0]              nre_q, nim_q;     // dividend magnitudes, shift out
	logic [SW:0]                rre_q, rim_q;     // partial remainders
	logic                       neg_re_q, neg_im_q;
	logic [CW-1:0]              step_q;
	logic                       zero_op;

	assign zero_op  = (br_q == '0) && (bi_q == '0);
	assign sts.is_div   = (mode_q == cci_pkg::OP_DIV) && !zero_op;
	assign sts.is_nop   = (mode_q > cci_pkg::OP_DIV);
	assign sts.div_last = (step_q == LAST_STEP);

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			br_q   <= operand_real;
			bi_q   <= operand_imag;
		end
	end

	// Products, three per product state (one multiplier per product register)
	always_ff @(posedge clk) begin
		if (cmd.mul_a) begin
			p_rr_q <= PW'(acc_re_q) * PW'(br_q);
			p_ii_q <= PW'(acc_im_q) * PW'(bi_q);
			p_bb_q <= PW'(br_q) * PW'(br_q);
		end
		if (cmd.mul_b) begin
			p_ri_q <= PW'(acc_re_q) * PW'(bi_q);
			p_ir_q <= PW'(acc_im_q) * PW'(br_q);
			p_cc_q <= PW'(bi_q) * PW'(bi_q);
		end
	end

	// Exact new values for non-divide operations and divide by zero (the maxima), and the dividends for divide
	logic signed [SW-1:0] sum_re, sum_im, dvd_re, dvd_im;
	always_comb begin
		sum_re = SW'(acc_re_q);
		sum_im = SW'(acc_im_q);
		unique case (mode_q)
			cci_pkg::OP_LOAD: begin
				sum_re = SW'(br_q);
				sum_im = SW'(bi_q);
			end
			cci_pkg::OP_ADD: begin
				sum_re = SW'(acc_re_q) + SW'(br_q);
				sum_im = SW'(acc_im_q) + SW'(bi_q);
			end
			cci_pkg::OP_SUB: begin
				sum_re = SW'(acc_re_q) - SW'(br_q);
				sum_im = SW'(acc_im_q) - SW'(bi_q);
			end
			cci_pkg::OP_MUL: begin
				sum_re = SW'(p_rr_q) - SW'(p_ii_q);
				sum_im = SW'(p_ri_q) + SW'(p_ir_q);
			end
			cci_pkg::OP_DIV: begin
				sum_re = SW'(real_max);
				sum_im = SW'(imag_max);
			end
			default: ;
		endcase
		dvd_re = SW'(p_rr_q) + SW'(p_ii_q);
		dvd_im = SW'(p_ir_q) - SW'(p_ri_q);
	end

	// Combine capture, divider load and restoring step on both quotients
	logic [SW:0] tre, tim;
	assign tre = {rre_q[SW-1:0], nre_q[QW-1]};
	assign tim = {rim_q[SW-1:0], nim_q[QW-1]};

	always_ff @(posedge clk) begin
		if (cmd.combine) begin
			new_re_q <= sum_re;
			new_im_q <= sum_im;
		end
		if (cmd.div_start) begin
			den_q    <= SW'(p_bb_q) + SW'(p_cc_q);
			neg_re_q <= dvd_re[SW-1];
			neg_im_q <= dvd_im[SW-1];
			nre_q    <= dvd_re[SW-1] ? QW'(-dvd_re) : QW'(dvd_re);
			nim_q    <= dvd_im[SW-1] ? QW'(-dvd_im) : QW'(dvd_im);
			rre_q    <= '0;
			rim_q    <= '0;
			step_q   <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + CW'(1);
			if (tre >= {1'b0, den_q}) begin
				rre_q <= tre - {1'b0, den_q};
				nre_q <= {nre_q[QW-2:0], 1'b1};
			end else begin
				rre_q <= tre;
				nre_q <= {nre_q[QW-2:0], 1'b0};
			end
			if (tim >= {1'b0, den_q}) begin
				rim_q <= tim - {1'b0, den_q};
				nim_q <= {nim_q[QW-2:0], 1'b1};
			end else begin
				rim_q <= tim;
				nim_q <= {nim_q[QW-2:0], 1'b0};
			end
			if (sts.div_last) begin
				new_re_q <= neg_re_q ? -SW'(signed'({1'b0, nre_q[QW-2:0], tre >= {1'b0, den_q}}))
				                     :  SW'(signed'({1'b0, nre_q[QW-2:0], tre >= {1'b0, den_q}}));
				new_im_q <= neg_im_q ? -SW'(signed'({1'b0, nim_q[QW-2:0], tim >= {1'b0, den_q}}))
				                     :  SW'(signed'({1'b0, nim_q[QW-2:0], tim >= {1'b0, den_q}}));
			end
		end
	end

	// Clamp: lower bound first
	logic signed [DW-1:0] cl_re, cl_im;
	logic                 hit_re, hit_im;
	always_comb begin
		hit_re = 1'b1;
		hit_im = 1'b1;
		priority if (new_re_q < SW'(real_min)) cl_re = real_min;
		else if (new_re_q > SW'(real_max))     cl_re = real_max;
		else begin
			cl_re  = DW'(new_re_q);
			hit_re = 1'b0;
		end
		priority if (new_im_q < SW'(imag_min)) cl_im = imag_min;
		else if (new_im_q > SW'(imag_max))     cl_im = imag_max;
		else begin
			cl_im  = DW'(new_im_q);
			hit_im = 1'b0;
		end
	end

	// Commit to accumulator and sticky flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			stk_re_q <= 1'b0;
			stk_im_q <= 1'b0;
		end else if (cmd.commit) begin
			acc_re_q <= cl_re;
			acc_im_q <= cl_im;
			stk_re_q <= hit_re || (stk_re_q && mode_q != cci_pkg::OP_LOAD);
			stk_im_q <= hit_im || (stk_im_q && mode_q != cci_pkg::OP_LOAD);
		end
	end

	assign result_real  = acc_re_q;
	assign result_imag  = acc_im_q;
	assign real_clamped = stk_re_q;
	assign imag_clamped = stk_im_q;

endmodule
`default_nettype wire

// ===== design/clamped_complex_integer_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clamped_complex_integer_alu: saturating complex integer accumulator
// Loads, adds, subtracts, multiplies or divides a complex accumulator and
// clamps each part to its own programmable range with sticky flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries mode and the operand; output
//   channel out_valid/out_ready carries the accumulator after the step and
//   the two sticky clamp flags. One result per item. The user must write
//   bounds (cfg_we/cfg_index/cfg_data) only while idle; this is not enforced.
// Sequence:
//   Load, add, subtract, multiply and divide-by-zero pass through capture,
//   the product states, combine, commit and result transfer; divide
//   loads the one-bit-per-cycle restoring divider in place of combine and
//   steps it to produce both quotients together before commit. Items are
//   handled one at a time; a new item is taken in the cycle its predecessor's
//   result transfers.
// Reset:
//   Accumulator and flags clear, bounds go to the full signed range.
//   A stalled receiver holds the result and blocks the next item.
// ----------------------------------------------------------------------------
module clamped_complex_integer_alu #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [DATA_WIDTH-1:0]        cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [2:0]                   mode,
	input  wire logic signed [DATA_WIDTH-1:0] operand_real,
	input  wire logic signed [DATA_WIDTH-1:0] operand_imag,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0]      result_real,
	output logic signed [DATA_WIDTH-1:0]      result_imag,
	output logic                              real_clamped,
	output logic                              imag_clamped
);

	localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [DATA_WIDTH-1:0] real_min_q, real_max_q, imag_min_q, imag_max_q;
	cci_pkg::cmd_t    cmd;
	cci_pkg::status_t sts;

	// Bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_min_q <= SMIN;
			real_max_q <= SMAX;
			imag_min_q <= SMIN;
			imag_max_q <= SMAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cci_pkg::REG_REAL_MIN: real_min_q <= cfg_data;
				cci_pkg::REG_REAL_MAX: real_max_q <= cfg_data;
				cci_pkg::REG_IMAG_MIN: imag_min_q <= cfg_data;
				cci_pkg::REG_IMAG_MAX: imag_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cci_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	cci_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .sts, .mode, .operand_real, .operand_imag,
		.real_min(real_min_q), .real_max(real_max_q),
		.imag_min(imag_min_q), .imag_max(imag_max_q),
		.result_real, .result_imag, .real_clamped, .imag_clamped
	);

endmodule
`default_nettype wire
